// ===== sv/sgbc_pkg.sv =====
// Shared types and codes for the sorted group-by counter table.
`timescale 1ns / 1ps

package sgbc_pkg;

	// Field widths fixed by the transaction format.
	localparam int KeyW   = 16;
	localparam int LenW   = 24;
	localparam int CntW   = 32;
	localparam int IdxW   = 5;
	localparam int StatW  = 3;
	localparam int UsedW  = 6;
	localparam int CfgW   = 16;
	localparam int RegIdW = 2;

	// Configuration register indexes.
	localparam logic [RegIdW-1:0] REG_TYPE_FILTER  = 2'd0;
	localparam logic [RegIdW-1:0] REG_QUAL_FILTER  = 2'd1;
	localparam logic [RegIdW-1:0] REG_SUMMARY_EN   = 2'd2;

	// Input transaction kinds.
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// Result status codes.
	localparam logic [StatW-1:0] ST_COUNTED    = 3'd0;
	localparam logic [StatW-1:0] ST_PASSED     = 3'd1;
	localparam logic [StatW-1:0] ST_FILTERED   = 3'd2;
	localparam logic [StatW-1:0] ST_FULL       = 3'd3;
	localparam logic [StatW-1:0] ST_READ_OK    = 3'd4;
	localparam logic [StatW-1:0] ST_READ_EMPTY = 3'd5;

	// Input transaction payload.
	typedef struct packed {
		logic            kind;
		logic [KeyW-1:0] record_type;
		logic [KeyW-1:0] record_qualifier;
		logic [LenW-1:0] record_bytes;
		logic [IdxW-1:0] read_index;
	} in_t;

	// Result transaction payload.
	typedef struct packed {
		logic [StatW-1:0] status;
		logic [KeyW-1:0]  entry_type;
		logic [KeyW-1:0]  entry_qualifier;
		logic [CntW-1:0]  entry_records;
		logic [CntW-1:0]  entry_bytes;
		logic [UsedW-1:0] entries_in_use;
		logic [CntW-1:0]  total_records;
		logic [CntW-1:0]  total_bytes;
	} out_t;

	// Contents of one table cell.
	typedef struct packed {
		logic [KeyW-1:0] key_type;
		logic [KeyW-1:0] key_qualifier;
		logic [CntW-1:0] records;
		logic [CntW-1:0] bytes;
	} entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic            insert;
		logic            count;
		logic [KeyW-1:0] rtype;
		logic [KeyW-1:0] rqual;
		logic [LenW-1:0] rbytes;
	} cell_cmd_t;

endpackage

// ===== sv/sgbc_cell.sv =====
// One cell of the sorted table: holds an entry, compares it, counts or shifts.
`timescale 1ns / 1ps

module sgbc_cell (
	input  logic               clk,
	input  logic               valid,
	input  sgbc_pkg::cell_cmd_t cmd,
	input  logic               prev_above,
	input  sgbc_pkg::entry_t   prev_entry,
	output logic               above,
	output logic               hit,
	output sgbc_pkg::entry_t   entry
);
	import sgbc_pkg::*;

	entry_t          entry_q;
	logic [2*KeyW-1:0] my_key;
	logic [2*KeyW-1:0] in_key;
	logic [CntW:0]   byte_sum;

	// Key compare; an empty cell sorts above every key.
	assign my_key = {entry_q.key_type, entry_q.key_qualifier};
	assign in_key = {cmd.rtype, cmd.rqual};
	assign above  = !valid || (my_key > in_key);
	assign hit    = valid && (my_key == in_key);
	assign entry  = entry_q;

	// Saturating byte sum for an existing entry.
	assign byte_sum  = {1'b0, entry_q.bytes} + (CntW+1)'(cmd.rbytes);

	// Count on a hit, or on insert take the new key or the neighbor's entry.
	always_ff @(posedge clk) begin
		if (cmd.count && hit) begin
			if (entry_q.records != '1) begin
				entry_q.records <= entry_q.records + 1'b1;
			end
			entry_q.bytes <= byte_sum[CntW] ? '1 : byte_sum[CntW-1:0];
		end else if (cmd.insert && above) begin
			if (!prev_above) begin
				entry_q.key_type      <= cmd.rtype;
				entry_q.key_qualifier <= cmd.rqual;
				entry_q.records       <= CntW'(1);
				entry_q.bytes         <= CntW'(cmd.rbytes);
			end else begin
				entry_q <= prev_entry;
			end
		end
	end

endmodule

// ===== sv/sorted_group_by_counter_table.sv =====
// Top level of the sorted group-by counter table: control, totals and cell chain.
//
//  Channel   Signals                          Direction  Moves
//  in        in_valid, in_ready, in_data      sink       record or read transaction
//  out       out_valid, out_ready, out_data   source     one result per transaction
//  cfg       cfg_we, cfg_index, cfg_data      sink       register write, no wait
//
// Each transaction is captured in a first step and applied, in a second step,
// to the whole chain of cells, which compare in parallel and shift on insert.
// The result sits in an output register, so the next transaction is taken
// while a result waits. A stalled output holds back the second step.
// Reset clears the fill count, the totals and the handshake state; the cells
// need no clearing since only cells below the fill count are ever used.
`timescale 1ns / 1ps

module sorted_group_by_counter_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sgbc_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sgbc_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [sgbc_pkg::RegIdW-1:0]   cfg_index,
	input  logic [sgbc_pkg::CfgW-1:0]     cfg_data
);
	import sgbc_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (CW > IdxW) ? CW : IdxW;

	logic [KeyW-1:0] type_filter_q;
	logic [KeyW-1:0] qual_filter_q;
	logic            summary_en_q;

	in_t             item_s1;
	logic            pend_s1;
	logic            step;

	logic [CW-1:0]   used_q;
	logic [CW-1:0]   used_d;
	logic [CntW-1:0] grand_rec_q;
	logic [CntW-1:0] grand_bytes_q;
	logic [CntW-1:0] grand_rec_d;
	logic [CntW-1:0] grand_bytes_d;
	logic [CntW:0]   grand_sum;

	out_t            out_q;
	logic            out_valid_q;
	out_t            result;

	cell_cmd_t       cmd;
	logic            is_record;
	logic            pass;
	logic            found;
	logic            full;
	logic            read_hit;
	entry_t          read_entry;

	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] above_vec;
	entry_t                 cell_ent [TABLE_DEPTH];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_filter_q <= '0;
			qual_filter_q <= '0;
			summary_en_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TYPE_FILTER: type_filter_q <= cfg_data;
				REG_QUAL_FILTER: qual_filter_q <= cfg_data;
				REG_SUMMARY_EN:  summary_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture stage; the second step runs once the output register is free.
	assign in_ready = !pend_s1;
	assign step     = pend_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			pend_s1 <= 1'b1;
		end else if (step) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Filter decision and the command broadcast along the chain.
	assign is_record = (item_s1.kind == KIND_RECORD);
	assign pass = ((type_filter_q == '0) || (item_s1.record_type == type_filter_q)) &&
	              ((qual_filter_q == '0) || (item_s1.record_qualifier == qual_filter_q));
	assign found = |hit_vec;
	assign full  = (used_q == CW'(TABLE_DEPTH));

	assign cmd.count  = step && is_record && pass && summary_en_q && found;
	assign cmd.insert = step && is_record && pass && summary_en_q && !found && !full;
	assign cmd.rtype  = item_s1.record_type;
	assign cmd.rqual  = item_s1.record_qualifier;
	assign cmd.rbytes = item_s1.record_bytes;

	// The chain of cells; on insert each cell above the new key takes its left neighbor's entry, or the new key if first.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   valid_i;
		logic   prev_above_i;
		entry_t prev_ent_i;

		assign valid_i = (CW'(i) < used_q);

		if (i == 0) begin : g_first
			assign prev_above_i = 1'b0;
			assign prev_ent_i   = cell_ent[0];
		end else begin : g_rest
			assign prev_above_i = above_vec[i-1];
			assign prev_ent_i   = cell_ent[i-1];
		end

		sgbc_cell u_cell (
			.clk        (clk),
			.valid      (valid_i),
			.cmd        (cmd),
			.prev_above (prev_above_i),
			.prev_entry (prev_ent_i),
			.above      (above_vec[i]),
			.hit        (hit_vec[i]),
			.entry      (cell_ent[i])
		);
	end

	// Read selection by sorted position.
	assign read_hit = (IW'(item_s1.read_index) < IW'(used_q));

	always_comb begin
		read_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (IW'(item_s1.read_index) == IW'(i)) begin
				read_entry = cell_ent[i];
			end
		end
	end

	// Fill count and saturating totals after this transaction.
	assign grand_sum = {1'b0, grand_bytes_q} + (CntW+1)'(item_s1.record_bytes);

	always_comb begin
		used_d        = used_q;
		grand_rec_d   = grand_rec_q;
		grand_bytes_d = grand_bytes_q;
		if (cmd.insert) begin
			used_d = used_q + 1'b1;
		end
		if (cmd.insert || cmd.count) begin
			if (grand_rec_q != '1) begin
				grand_rec_d = grand_rec_q + 1'b1;
			end
			grand_bytes_d = grand_sum[CntW] ? '1 : grand_sum[CntW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			grand_rec_q   <= '0;
			grand_bytes_q <= '0;
		end else begin
			used_q        <= used_d;
			grand_rec_q   <= grand_rec_d;
			grand_bytes_q <= grand_bytes_d;
		end
	end

	// Result assembly.
	always_comb begin
		result                = '0;
		result.entries_in_use = UsedW'(used_d);
		result.total_records  = grand_rec_d;
		result.total_bytes    = grand_bytes_d;
		if (!is_record) begin
			if (read_hit) begin
				result.status          = ST_READ_OK;
				result.entry_type      = read_entry.key_type;
				result.entry_qualifier = read_entry.key_qualifier;
				result.entry_records   = read_entry.records;
				result.entry_bytes     = read_entry.bytes;
			end else begin
				result.status = ST_READ_EMPTY;
			end
		end else if (!pass) begin
			result.status = ST_FILTERED;
		end else if (!summary_en_q) begin
			result.status = ST_PASSED;
		end else if (!found && full) begin
			result.status = ST_FULL;
		end else begin
			result.status = ST_COUNTED;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The fill count never passes the number of cells.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// Sorted distinct keys: at most one cell matches a key.
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> $onehot0(hit_vec))
		else $error("more than one cell holds the same key");

	// An insert grows the table by exactly one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> (used_q == $past(used_q) + 1'b1))
		else $error("insert did not advance the fill count");

	// Only the second step changes the table.
	a_step_only: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> (used_q == $past(used_q)) && (grand_rec_q == $past(grand_rec_q)))
		else $error("table changed outside a transaction step");

endmodule
